### design/sqni_pkg.sv
// Package for the segment/quad intersect block: widths, register codes,
// the divider cell beat type and the hit-candidate pick functions.
// No dependencies.
`timescale 1ns / 1ps

package sqni_pkg;

	localparam int CW   = 24;          // coordinate width, Q15.8
	localparam int FB   = 8;           // fraction bits
	localparam int DW   = CW + 1;      // coordinate difference
	localparam int PW   = 2 * DW;      // product of two differences
	localparam int XW   = PW + 1;      // cross product
	localparam int MW   = XW - 1;      // cross product magnitude
	localparam int HW   = MW / 2;      // half of a magnitude, for split multiply
	localparam int PPW  = (MW - HW) + CW; // partial product
	localparam int QW   = CW;          // quotient bits
	localparam int NW   = MW + QW;     // dividend
	localparam int DSW  = 2 * CW + 1;  // squared distance
	localparam int THRW = 20;
	localparam int LIMW = 24;
	localparam int LSQW = 2 * LIMW;
	localparam int CFGW = 24;
	localparam int NEDGE = 4;
	localparam int LAT  = 35;          // accept to result strobe

	localparam logic [THRW-1:0] THR_RESET    = THRW'(7);
	localparam logic [LIMW-1:0] LIM_RESET    = LIMW'(2560000);
	localparam logic [LSQW-1:0] LIM_SQ_RESET = LSQW'(64'd6553600000000);
	localparam logic [CW-1:0]   MISS_COORD   = ~(CW'(1) << FB) + CW'(1);

	typedef enum logic {
		REG_THR = 1'b0,
		REG_LIM = 1'b1
	} reg_idx_t;

	// one beat through the divider row
	typedef struct packed {
		logic          hit;
		logic          neg;
		logic [MW-1:0] rem;
		logic [MW-1:0] den;
		logic [QW-1:0] nlow;
		logic [QW-1:0] quo;
	} div_t;

	typedef struct packed {
		logic           ok;
		logic [DSW-1:0] dsq;
		logic [CW-1:0]  x;
		logic [CW-1:0]  y;
	} cand_t;

	// left side wins ties, so lower edges win
	function automatic cand_t pick_near(input cand_t a, input cand_t b);
		return (b.ok && (!a.ok || (b.dsq < a.dsq))) ? b : a;
	endfunction

	function automatic cand_t pick_far(input cand_t a, input cand_t b);
		return (b.ok && (!a.ok || (b.dsq > a.dsq))) ? b : a;
	endfunction

endpackage

### design/sqni_div_cell.sv
// One restoring-division cell: resolves one quotient bit per beat.
// Depends on sqni_pkg.
`timescale 1ns / 1ps

module sqni_div_cell import sqni_pkg::*; (
	input  logic clk,
	input  div_t d_in,
	output div_t d_out
);

	logic [MW:0] trial;
	logic [MW:0] diff;
	logic        ge;
	div_t        nxt;

	always_comb begin
		trial = {d_in.rem, d_in.nlow[QW-1]};
		diff  = trial - {1'b0, d_in.den};
		ge    = trial >= {1'b0, d_in.den};
		nxt      = d_in;
		nxt.rem  = ge ? diff[MW-1:0] : trial[MW-1:0];
		nxt.nlow = d_in.nlow << 1;
		nxt.quo  = {d_in.quo[QW-2:0], ge};
	end

	always_ff @(posedge clk) begin
		d_out <= nxt;
	end

endmodule

### design/sqni_divider.sv
// Row of QW division cells; one quotient bit per stage, one beat per cycle.
// Depends on sqni_pkg and sqni_div_cell.
`timescale 1ns / 1ps

module sqni_divider import sqni_pkg::*; (
	input  logic clk,
	input  div_t d_in,
	output div_t d_out
);

	div_t stage [0:QW];

	assign stage[0] = d_in;

	for (genvar k = 0; k < QW; k++) begin : g_cell
		sqni_div_cell u_cell (
			.clk   (clk),
			.d_in  (stage[k]),
			.d_out (stage[k+1])
		);
	end

	assign d_out = stage[QW];

endmodule

### design/sqni_edge.sv
// Per-edge datapath: perp products, parallel and range tests, scaled
// numerators, then two divider rows for the hit offset. Depends on sqni_pkg,
// sqni_divider.
`timescale 1ns / 1ps

module sqni_edge import sqni_pkg::*; (
	input  logic                   clk,
	input  logic        [THRW-1:0] thr,
	input  logic signed [CW-1:0]   sx,
	input  logic signed [CW-1:0]   sy,
	input  logic signed [CW-1:0]   ex,
	input  logic signed [CW-1:0]   ey,
	input  logic signed [CW-1:0]   ax,
	input  logic signed [CW-1:0]   ay,
	input  logic signed [CW-1:0]   bx,
	input  logic signed [CW-1:0]   by,
	output div_t                   qx,
	output div_t                   qy
);

	logic signed [DW-1:0] ux_s2, uy_s2, vx_s2, vy_s2, wx_s2, wy_s2;
	logic signed [PW-1:0] d1_s3, d2_s3, s1_s3, s2_s3, t1_s3, t2_s3;
	logic signed [DW-1:0] ux_s3, uy_s3, ux_s4, uy_s4;
	logic signed [XW-1:0] d_s4, sn_s4, tn_s4;
	logic signed [XW-1:0] d_n, sn_n, tn_n;
	logic [MW-1:0]        d_abs, sn_abs, tn_abs;
	logic [CW-1:0]        uxa, uya;
	logic                 unit_sn, unit_tn;
	logic                 ok_s5, negx_s5, negy_s5, ok_s6, negx_s6, negy_s6;
	logic [MW-1:0]        dabs_s5, snabs_s5, dabs_s6;
	logic [CW-1:0]        uxa_s5, uya_s5;
	logic [PPW-1:0]       pxl_s6, pxh_s6, pyl_s6, pyh_s6;
	logic [NW-1:0]        nx, ny;
	div_t                 dx_s7, dy_s7;

	always_ff @(posedge clk) begin
		ux_s2 <= DW'(ex) - DW'(sx);
		uy_s2 <= DW'(ey) - DW'(sy);
		vx_s2 <= DW'(bx) - DW'(ax);
		vy_s2 <= DW'(by) - DW'(ay);
		wx_s2 <= DW'(sx) - DW'(ax);
		wy_s2 <= DW'(sy) - DW'(ay);
	end

	always_ff @(posedge clk) begin
		d1_s3 <= ux_s2 * vy_s2;
		d2_s3 <= uy_s2 * vx_s2;
		s1_s3 <= vx_s2 * wy_s2;
		s2_s3 <= vy_s2 * wx_s2;
		t1_s3 <= ux_s2 * wy_s2;
		t2_s3 <= uy_s2 * wx_s2;
		ux_s3 <= ux_s2;
		uy_s3 <= uy_s2;
	end

	always_ff @(posedge clk) begin
		d_s4  <= XW'(d1_s3) - XW'(d2_s3);
		sn_s4 <= XW'(s1_s3) - XW'(s2_s3);
		tn_s4 <= XW'(t1_s3) - XW'(t2_s3);
		ux_s4 <= ux_s3;
		uy_s4 <= uy_s3;
	end

	// sign/magnitude range test for n/d in [0,1]
	always_comb begin
		d_n    = -d_s4;
		sn_n   = -sn_s4;
		tn_n   = -tn_s4;
		d_abs  = d_s4[XW-1]  ? d_n[MW-1:0]  : d_s4[MW-1:0];
		sn_abs = sn_s4[XW-1] ? sn_n[MW-1:0] : sn_s4[MW-1:0];
		tn_abs = tn_s4[XW-1] ? tn_n[MW-1:0] : tn_s4[MW-1:0];
		uxa    = ux_s4[DW-1] ? CW'(-ux_s4) : CW'(ux_s4);
		uya    = uy_s4[DW-1] ? CW'(-uy_s4) : CW'(uy_s4);
		unit_sn = (sn_s4 == '0) ||
			((sn_s4[XW-1] == d_s4[XW-1]) && (d_abs >= sn_abs));
		unit_tn = (tn_s4 == '0) ||
			((tn_s4[XW-1] == d_s4[XW-1]) && (d_abs >= tn_abs));
	end

	always_ff @(posedge clk) begin
		ok_s5    <= (d_s4 != '0) && (d_abs >= MW'(thr)) && unit_sn && unit_tn;
		negx_s5  <= sn_s4[XW-1] ^ d_s4[XW-1] ^ ux_s4[DW-1];
		negy_s5  <= sn_s4[XW-1] ^ d_s4[XW-1] ^ uy_s4[DW-1];
		dabs_s5  <= d_abs;
		snabs_s5 <= sn_abs;
		uxa_s5   <= uxa;
		uya_s5   <= uya;
	end

	// |sn| * |u| split in two halves
	always_ff @(posedge clk) begin
		pxl_s6  <= PPW'(snabs_s5[HW-1:0]) * PPW'(uxa_s5);
		pxh_s6  <= PPW'(snabs_s5[MW-1:HW]) * PPW'(uxa_s5);
		pyl_s6  <= PPW'(snabs_s5[HW-1:0]) * PPW'(uya_s5);
		pyh_s6  <= PPW'(snabs_s5[MW-1:HW]) * PPW'(uya_s5);
		ok_s6   <= ok_s5;
		negx_s6 <= negx_s5;
		negy_s6 <= negy_s5;
		dabs_s6 <= dabs_s5;
	end

	always_comb begin
		nx = (NW'(pxh_s6) << HW) + NW'(pxl_s6);
		ny = (NW'(pyh_s6) << HW) + NW'(pyl_s6);
	end

	// quotient is below 2^QW, so the top MW bits are already below the divisor
	always_ff @(posedge clk) begin
		dx_s7.hit  <= ok_s6;
		dx_s7.neg  <= negx_s6;
		dx_s7.rem  <= nx[NW-1:QW];
		dx_s7.den  <= dabs_s6;
		dx_s7.nlow <= nx[QW-1:0];
		dx_s7.quo  <= '0;
		dy_s7.hit  <= ok_s6;
		dy_s7.neg  <= negy_s6;
		dy_s7.rem  <= ny[NW-1:QW];
		dy_s7.den  <= dabs_s6;
		dy_s7.nlow <= ny[QW-1:0];
		dy_s7.quo  <= '0;
	end

	sqni_divider u_div_x (
		.clk   (clk),
		.d_in  (dx_s7),
		.d_out (qx)
	);

	sqni_divider u_div_y (
		.clk   (clk),
		.d_in  (dy_s7),
		.d_out (qy)
	);

endmodule

### design/segment_quad_near_far_intersect.sv
// Top level: segment versus quadrilateral, nearest and farthest hit point.
// Depends on sqni_pkg, sqni_edge (and through it the divider cell row).
//
// Usage:
//   Command in: a beat is taken on a rising edge with start high and busy
//   low. busy is always low; a new segment and quad may be issued every
//   cycle, and beats in flight do not interact.
//   Result out: done is high for exactly one cycle, with hit, near_x/y
//   and far_x/y valid in that cycle. The receiver cannot stall; results
//   appear in command order.
//   The pipeline is built around the divider row: one cell per quotient bit (24 cells)
//   after seven stages of differences, perp products, range tests and
//   scaled numerators, followed by four stages of distance and selection.
//   Throughput is one beat per cycle.
//   Config: cfg_we writes register cfg_addr (0 parallel threshold,
//   1 near range limit) at once. Write only while nothing is in flight.
//   Reset: arst_n clears the valid pipeline and loads register defaults;
//   no result strobes until new commands arrive.
`timescale 1ns / 1ps

module segment_quad_near_far_intersect import sqni_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [CW-1:0] ray_start_x,
	input  logic signed [CW-1:0] ray_start_y,
	input  logic signed [CW-1:0] ray_end_x,
	input  logic signed [CW-1:0] ray_end_y,
	input  logic signed [CW-1:0] corner0_x,
	input  logic signed [CW-1:0] corner0_y,
	input  logic signed [CW-1:0] corner1_x,
	input  logic signed [CW-1:0] corner1_y,
	input  logic signed [CW-1:0] corner2_x,
	input  logic signed [CW-1:0] corner2_y,
	input  logic signed [CW-1:0] corner3_x,
	input  logic signed [CW-1:0] corner3_y,
	input  logic                 cfg_we,
	input  reg_idx_t             cfg_addr,
	input  logic [CFGW-1:0]      cfg_wdata,
	output logic                 done,
	output logic                 hit,
	output logic signed [CW-1:0] near_x,
	output logic signed [CW-1:0] near_y,
	output logic signed [CW-1:0] far_x,
	output logic signed [CW-1:0] far_y
);

	logic [THRW-1:0] thr_q;
	logic [LIMW-1:0] lim_q;
	logic [LSQW-1:0] lim_sq_q;
	logic [1:LAT]    vld_q;

	logic signed [CW-1:0] sx_s1, sy_s1, ex_s1, ey_s1;
	logic signed [CW-1:0] cx_s1 [NEDGE];
	logic signed [CW-1:0] cy_s1 [NEDGE];
	logic [CW-1:0]        sxp [2:31];
	logic [CW-1:0]        syp [2:31];

	div_t            qx_s31 [NEDGE];
	div_t            qy_s31 [NEDGE];
	logic [CW-1:0]   hx_s32 [NEDGE];
	logic [CW-1:0]   hy_s32 [NEDGE];
	logic [2*CW-1:0] sqx_s32 [NEDGE];
	logic [2*CW-1:0] sqy_s32 [NEDGE];
	logic            hit_s32 [NEDGE];
	cand_t           near_s33 [NEDGE];
	cand_t           far_s33 [NEDGE];
	cand_t           n01_s34, n23_s34, f01_s34, f23_s34;
	cand_t           n_best, f_best;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			lim_q    <= LIM_RESET;
			lim_sq_q <= LIM_SQ_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_THR: thr_q <= cfg_wdata[THRW-1:0];
					REG_LIM: lim_q <= cfg_wdata[LIMW-1:0];
					default: ;
				endcase
			end
			lim_sq_q <= LSQW'(lim_q) * LSQW'(lim_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {start && !busy, vld_q[1:LAT-1]};
		end
	end

	always_ff @(posedge clk) begin
		sx_s1    <= ray_start_x;
		sy_s1    <= ray_start_y;
		ex_s1    <= ray_end_x;
		ey_s1    <= ray_end_y;
		cx_s1[0] <= corner0_x;
		cy_s1[0] <= corner0_y;
		cx_s1[1] <= corner1_x;
		cy_s1[1] <= corner1_y;
		cx_s1[2] <= corner2_x;
		cy_s1[2] <= corner2_y;
		cx_s1[3] <= corner3_x;
		cy_s1[3] <= corner3_y;
		sxp[2]   <= sx_s1;
		syp[2]   <= sy_s1;
		for (int k = 3; k <= 31; k++) begin
			sxp[k] <= sxp[k-1];
			syp[k] <= syp[k-1];
		end
	end

	for (genvar e = 0; e < NEDGE; e++) begin : g_edge
		localparam int NXT = (e + 1) % NEDGE;

		logic [DW-1:0] qsx, qsy;

		sqni_edge u_edge (
			.clk (clk),
			.thr (thr_q),
			.sx  (sx_s1),
			.sy  (sy_s1),
			.ex  (ex_s1),
			.ey  (ey_s1),
			.ax  (cx_s1[e]),
			.ay  (cy_s1[e]),
			.bx  (cx_s1[NXT]),
			.by  (cy_s1[NXT]),
			.qx  (qx_s31[e]),
			.qy  (qy_s31[e])
		);

		always_comb begin
			qsx = qx_s31[e].neg ? -DW'(qx_s31[e].quo) : DW'(qx_s31[e].quo);
			qsy = qy_s31[e].neg ? -DW'(qy_s31[e].quo) : DW'(qy_s31[e].quo);
		end

		always_ff @(posedge clk) begin
			hx_s32[e]  <= sxp[31] + qsx[CW-1:0];
			hy_s32[e]  <= syp[31] + qsy[CW-1:0];
			sqx_s32[e] <= (2*CW)'(qx_s31[e].quo) * (2*CW)'(qx_s31[e].quo);
			sqy_s32[e] <= (2*CW)'(qy_s31[e].quo) * (2*CW)'(qy_s31[e].quo);
			hit_s32[e] <= qx_s31[e].hit;
		end

		always_ff @(posedge clk) begin
			near_s33[e].dsq <= DSW'(sqx_s32[e]) + DSW'(sqy_s32[e]);
			near_s33[e].ok  <= hit_s32[e] &&
				((DSW'(sqx_s32[e]) + DSW'(sqy_s32[e])) < DSW'(lim_sq_q));
			near_s33[e].x   <= hx_s32[e];
			near_s33[e].y   <= hy_s32[e];
			far_s33[e].dsq  <= DSW'(sqx_s32[e]) + DSW'(sqy_s32[e]);
			far_s33[e].ok   <= hit_s32[e];
			far_s33[e].x    <= hx_s32[e];
			far_s33[e].y    <= hy_s32[e];
		end
	end

	always_ff @(posedge clk) begin
		n01_s34 <= pick_near(near_s33[0], near_s33[1]);
		n23_s34 <= pick_near(near_s33[2], near_s33[3]);
		f01_s34 <= pick_far(far_s33[0], far_s33[1]);
		f23_s34 <= pick_far(far_s33[2], far_s33[3]);
	end

	always_comb begin
		n_best = pick_near(n01_s34, n23_s34);
		f_best = pick_far(f01_s34, f23_s34);
	end

	// a near hit implies a far hit, so near alone decides the miss case
	always_ff @(posedge clk) begin
		hit    <= n_best.ok;
		near_x <= n_best.ok ? n_best.x : '0;
		near_y <= n_best.ok ? n_best.y : '0;
		far_x  <= n_best.ok ? f_best.x : MISS_COORD;
		far_y  <= n_best.ok ? f_best.y : MISS_COORD;
	end

	assign done = vld_q[LAT];

	a_miss_default: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> near_x == '0 && near_y == '0 &&
			far_x == MISS_COORD && far_y == MISS_COORD)
		else $error("miss beat without default coordinates");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result strobe without a command beat");

endmodule

### verif/tb_top.sv
// Testbench for segment_quad_near_far_intersect: segment vs quad near/far hit checks.
// Holds a scoreboard class with its own predictor; depends on sqni_pkg and the block.
`timescale 1ns / 1ps

module tb_top;
	import sqni_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [CW-1:0] sx, sy, ex, ey;
		logic signed [CW-1:0] cx [4];
		logic signed [CW-1:0] cy [4];
	} seg_quad_t;

	typedef struct {
		logic                 hit;
		logic signed [CW-1:0] nx, ny, fx, fy;
	} hit_pair_t;

	class hit_scoreboard;
		hit_pair_t      pending_hits[$];
		logic [THRW-1:0] thr = THR_RESET;
		logic [LIMW-1:0] lim = LIM_RESET;
		int             mismatches = 0;

		function wide_t mag(wide_t v);
			return (v < 0) ? -v : v;
		endfunction

		// ratio n/d within [0,1] without dividing
		function bit unit_ok(wide_t n, wide_t d);
			if (n == 0)
				return 1;
			if ((n < 0) != (d < 0))
				return 0;
			return mag(d) >= mag(n);
		endfunction

		function hit_pair_t predict(seg_quad_t it);
			hit_pair_t r;
			wide_t ux, uy, vx, vy, wx, wy, d, sn, tn, qx, qy, d2, bn, bf, hx, hy;
			wide_t nx, ny, fx, fy;
			bit gn, gf;
			int j;
			ux = wide_t'(it.ex) - wide_t'(it.sx);
			uy = wide_t'(it.ey) - wide_t'(it.sy);
			bn = $signed({104'b0, lim}) * $signed({104'b0, lim});
			bf = 0;
			gn = 0;
			gf = 0;
			nx = 0; ny = 0; fx = 0; fy = 0;
			for (int i = 0; i < NEDGE; i++) begin
				j = (i + 1) % NEDGE;
				vx = wide_t'(it.cx[j]) - wide_t'(it.cx[i]);
				vy = wide_t'(it.cy[j]) - wide_t'(it.cy[i]);
				wx = wide_t'(it.sx) - wide_t'(it.cx[i]);
				wy = wide_t'(it.sy) - wide_t'(it.cy[i]);
				d = ux * vy - uy * vx;
				if (d == 0 || mag(d) < $signed({108'b0, thr}))
					continue;
				sn = vx * wy - vy * wx;
				if (!unit_ok(sn, d))
					continue;
				tn = ux * wy - uy * wx;
				if (!unit_ok(tn, d))
					continue;
				qx = (sn * ux) / d;
				qy = (sn * uy) / d;
				hx = wide_t'(it.sx) + qx;
				hy = wide_t'(it.sy) + qy;
				d2 = qx * qx + qy * qy;
				if (d2 < bn) begin
					bn = d2; nx = hx; ny = hy; gn = 1;
				end
				if (!gf || d2 > bf) begin
					bf = d2; fx = hx; fy = hy; gf = 1;
				end
			end
			r.hit = gn && gf;
			if (r.hit) begin
				r.nx = nx[CW-1:0]; r.ny = ny[CW-1:0];
				r.fx = fx[CW-1:0]; r.fy = fy[CW-1:0];
			end else begin
				r.nx = '0; r.ny = '0;
				r.fx = MISS_COORD; r.fy = MISS_COORD;
			end
			return r;
		endfunction

		function void note_beat(seg_quad_t it);
			pending_hits.push_back(predict(it));
		endfunction

		function void check_result(hit_pair_t got);
			hit_pair_t exp_r;
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing pending: hit=%0d", got.hit);
				return;
			end
			exp_r = pending_hits.pop_front();
			if (got.hit !== exp_r.hit || got.nx !== exp_r.nx || got.ny !== exp_r.ny
					|| got.fx !== exp_r.fx || got.fy !== exp_r.fy) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: exp hit=%0d n=(%0d,%0d) f=(%0d,%0d)",
						" got hit=%0d n=(%0d,%0d) f=(%0d,%0d)"},
						exp_r.hit, exp_r.nx, exp_r.ny, exp_r.fx, exp_r.fy,
						got.hit, got.nx, got.ny, got.fx, got.fy);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0, start = 0, busy, cfg_we = 0, done, hit;
	reg_idx_t cfg_addr = REG_THR;
	logic [CFGW-1:0] cfg_wdata = '0;
	seg_quad_t cur = '{default: '0, cx: '{default: '0}, cy: '{default: '0}};
	logic signed [CW-1:0] near_x, near_y, far_x, far_y;
	hit_scoreboard sb = new();
	int cycles = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	segment_quad_near_far_intersect i_dut (
		.clk, .arst_n, .start, .busy,
		.ray_start_x(cur.sx), .ray_start_y(cur.sy), .ray_end_x(cur.ex), .ray_end_y(cur.ey),
		.corner0_x(cur.cx[0]), .corner0_y(cur.cy[0]), .corner1_x(cur.cx[1]),
		.corner1_y(cur.cy[1]), .corner2_x(cur.cx[2]), .corner2_y(cur.cy[2]),
		.corner3_x(cur.cx[3]), .corner3_y(cur.cy[3]),
		.cfg_we, .cfg_addr, .cfg_wdata, .done, .hit, .near_x, .near_y, .far_x, .far_y
	);

	// monitor: sees pre-edge values of everything
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{hit: hit, nx: near_x, ny: near_y, fx: far_x, fy: far_y});
		if (arst_n && start && !busy)
			sb.note_beat(cur);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [CFGW-1:0] val);
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_THR)
			sb.thr = val[THRW-1:0];
		else
			sb.lim = val[LIMW-1:0];
	endtask

	// drive one beat; start stays high until the caller idles
	task automatic send_beat(seg_quad_t it);
		start <= 1;
		cur <= it;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle(int n);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending_hits.size() != 0)
			@(posedge clk);
		repeat (LAT + 5) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] near_pt(int c, int spread);
		return CW'(c + $signed($urandom_range(0, 2 * spread)) - spread);
	endfunction

	function automatic seg_quad_t rand_item();
		seg_quad_t it;
		int c_x, c_y, s, mode;
		mode = $urandom_range(0, 9);
		c_x = $signed($urandom_range(0, 200000)) - 100000;
		c_y = $signed($urandom_range(0, 200000)) - 100000;
		s = (mode < 7) ? $urandom_range(1, 3000) : $urandom_range(1, 3000000);
		if (mode == 9) begin
			it.sx = CW'($urandom()); it.sy = CW'($urandom());
			it.ex = CW'($urandom()); it.ey = CW'($urandom());
			for (int i = 0; i < 4; i++) begin
				it.cx[i] = CW'($urandom()); it.cy[i] = CW'($urandom());
			end
		end else begin
			// quad around a center, corners in angular order
			it.cx[0] = near_pt(c_x - s, s / 2); it.cy[0] = near_pt(c_y - s, s / 2);
			it.cx[1] = near_pt(c_x + s, s / 2); it.cy[1] = near_pt(c_y - s, s / 2);
			it.cx[2] = near_pt(c_x + s, s / 2); it.cy[2] = near_pt(c_y + s, s / 2);
			it.cx[3] = near_pt(c_x - s, s / 2); it.cy[3] = near_pt(c_y + s, s / 2);
			it.sx = near_pt(c_x, 3 * s); it.sy = near_pt(c_y, 3 * s);
			it.ex = near_pt(c_x, 3 * s); it.ey = near_pt(c_y, 3 * s);
			if (mode == 8)
				it.cx[2] = it.cx[1]; // exactly vertical edge
			if (mode == 6) begin
				it.ex = it.sx; it.ey = it.sy;
			end
		end
		return it;
	endfunction

	function automatic seg_quad_t box(int x0, int y0, int x1, int y1,
			int sx, int sy, int ex, int ey);
		seg_quad_t it;
		it.cx[0] = CW'(x0); it.cy[0] = CW'(y0); it.cx[1] = CW'(x1); it.cy[1] = CW'(y0);
		it.cx[2] = CW'(x1); it.cy[2] = CW'(y1); it.cx[3] = CW'(x0); it.cy[3] = CW'(y1);
		it.sx = CW'(sx); it.sy = CW'(sy); it.ex = CW'(ex); it.ey = CW'(ey);
		return it;
	endfunction

	task automatic run_random(int n);
		int left, burst;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst && left > 0; k++, left--)
				send_beat(rand_item());
			if ($urandom_range(0, 3) != 0)
				idle($urandom_range(1, 8));
		end
		drain();
	endtask

	initial begin
		seg_quad_t z;
		z = box(0, 0, 0, 0, 0, 0, 0, 0);
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed beats at reset settings
		send_beat(z);                                          // all degenerate
		send_beat(box(-256, -256, 256, 256, -1024, 0, 1024, 0)); // crosses the left and right sides
		send_beat(box(-256, -256, 256, 256, 0, 0, 1024, 0));    // starts inside
		send_beat(box(-256, -256, 256, 256, -1024, -1024, 1024, 1024)); // corner ties
		send_beat(box(-256, -256, 256, 256, -1024, -256, 1024, -256)); // along an edge
		send_beat(box(-256, -256, 256, 256, 512, 512, 1024, 1024)); // clean miss
		send_beat(box(-256, -256, 256, 256, -256, 0, 256, 0));  // endpoints on edges
		idle(2);
		send_beat(box(-8388608, -8388608, 8388607, 8388607,
			-8388608, 0, 8388607, 0));                           // full span, out of range
		send_beat(box(8388607, 8388607, -8388608, -8388608,
			8388607, -8388608, -8388608, 8388607));
		send_beat(box(-8388608, -8388608, -8388608, 8388607,
			-8388608, -8388608, 8388607, 8388607));
		send_beat(box(100000, 100000, 100003, 100003, 99999, 100001, 100004, 100002));
		drain();
		run_random(100);

		write_reg(REG_THR, '0);
		write_reg(REG_LIM, 24'hFFFFFF);
		send_beat(box(-8388608, -8388608, 8388607, 8388607,
			-8388608, 0, 8388607, 0));
		send_beat(box(0, 0, 1, 1, 0, 0, 1, 1));                 // tiny cross product
		send_beat(box(0, 0, 2, 2, 1, -5, 1, 5));
		drain();
		run_random(100);

		write_reg(REG_THR, 24'h0FFFFF);
		write_reg(REG_LIM, '0);
		send_beat(box(-256, -256, 256, 256, -1024, 0, 1024, 0));
		send_beat(box(-100000, -100000, 100000, 100000, -300000, 7, 300000, -9));
		drain();
		run_random(100);

		write_reg(REG_THR, 24'(1));
		write_reg(REG_LIM, 24'($urandom_range(1, 5000)));
		run_random(100);

		write_reg(REG_THR, 24'($urandom_range(0, 1048575)));
		write_reg(REG_LIM, 24'($urandom_range(0, 16777215)));
		run_random(100);

		if (sb.mismatches == 0 && sb.pending_hits.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
